### src/display_app_carousel_sequencer_assert.svh
// Assertion macros shared by the carousel sequencer RTL.
// Every check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef DISPLAY_APP_CAROUSEL_SEQUENCER_ASSERT_SVH
`define DISPLAY_APP_CAROUSEL_SEQUENCER_ASSERT_SVH

// A property that must hold at every sampled edge.
`define DACS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition whose consequence must hold in the next cycle.
`define DACS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/dacs_pkg.sv
// ---------------------------------------------------------------------------
// Carousel sequencer package
// Widths, codes, payload types and the neighbor function of the sequencer.
// ---------------------------------------------------------------------------
package dacs_pkg;

    localparam int MAX_APPS   = 32;
    localparam int COUNT_BITS = 16;
    localparam int APP_BITS   = 5;
    localparam int APP_CNT_W  = 6;
    localparam int TARGET_W   = 8;
    localparam int SKIP_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [APP_CNT_W-1:0]  APP_COUNT_RST       = '0;
    localparam logic [COUNT_BITS-1:0] TICKS_PER_APP_RST   = 16'd150;
    localparam logic [COUNT_BITS-1:0] TICKS_PER_TRANS_RST = 16'd15;
    localparam logic [APP_CNT_W-1:0]  MAX_APPS_CNT        = APP_CNT_W'(MAX_APPS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX           = '1;

    typedef enum logic [2:0] {
        ACT_TICK     = 3'd0,
        ACT_NEXT     = 3'd1,
        ACT_PREV     = 3'd2,
        ACT_JUMP     = 3'd3,
        ACT_GOTO     = 3'd4,
        ACT_RESET    = 3'd5,
        ACT_FORWARD  = 3'd6,
        ACT_BACKWARD = 3'd7
    } dacs_action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_APP_COUNT       = 2'd0,
        CFG_TICKS_PER_APP   = 2'd1,
        CFG_TICKS_PER_TRANS = 2'd2,
        CFG_AUTO_ENABLE     = 2'd3
    } dacs_cfg_idx_t;

    typedef struct packed {
        logic [APP_CNT_W-1:0]  app_count;
        logic [COUNT_BITS-1:0] ticks_per_app;
        logic [COUNT_BITS-1:0] ticks_per_trans;
        logic                  auto_enable;
    } dacs_cfg_t;

    typedef struct packed {
        dacs_action_t        action;
        logic [TARGET_W-1:0] target_app;
        logic [SKIP_W-1:0]   skipped_ticks;
    } dacs_in_t;

    typedef struct packed {
        logic [APP_BITS-1:0]   current_app;
        logic [APP_BITS-1:0]   next_app;
        logic                  transitioning;
        logic [COUNT_BITS-1:0] tick_count;
        logic                  backward;
        logic                  switched;
    } dacs_out_t;

    typedef struct packed {
        logic                  phase;
        logic [APP_BITS-1:0]   current_index;
        logic [COUNT_BITS-1:0] tick_counter;
        logic                  dir_backward;
        logic                  manual_flag;
        logic                  pending_valid;
        logic [APP_BITS-1:0]   pending_index;
    } dacs_state_t;

    // App that follows the current one: the pending target if set, otherwise
    // the wrapped neighbor in the current direction.
    function automatic logic [APP_BITS-1:0] dacs_neighbor(
        input logic [APP_CNT_W-1:0] n,
        input dacs_state_t          st
    );
        logic [APP_CNT_W-1:0] cur_ext;
        logic [APP_BITS-1:0]  result;
        cur_ext = {1'b0, st.current_index};
        result  = '0;
        if (st.pending_valid) begin
            result = st.pending_index;
        end else if (n == '0) begin
            result = '0;
        end else if (st.dir_backward) begin
            if (cur_ext == '0) begin
                result = APP_BITS'(n - 1'b1);
            end else if ((cur_ext - 1'b1) >= n) begin
                result = '0;
            end else begin
                result = APP_BITS'(cur_ext - 1'b1);
            end
        end else begin
            if ((cur_ext + 1'b1) >= n) begin
                result = '0;
            end else begin
                result = APP_BITS'(cur_ext + 1'b1);
            end
        end
        return result;
    endfunction

endpackage

### src/dacs_cfg.sv
// ---------------------------------------------------------------------------
// Carousel sequencer configuration registers
// Holds the rotation size, the dwell and transition lengths and the auto flag.
// ---------------------------------------------------------------------------
module dacs_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dacs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dacs_pkg::CFG_DATA_W-1:0]   cfg_data,
    output dacs_pkg::dacs_cfg_t               cfg
);
    import dacs_pkg::*;

    dacs_cfg_t cfg_reg;
    dacs_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (dacs_cfg_idx_t'(cfg_index))
                CFG_APP_COUNT:       cfg_next.app_count       = cfg_data[APP_CNT_W-1:0];
                CFG_TICKS_PER_APP:   cfg_next.ticks_per_app   = cfg_data[COUNT_BITS-1:0];
                CFG_TICKS_PER_TRANS: cfg_next.ticks_per_trans = cfg_data[COUNT_BITS-1:0];
                CFG_AUTO_ENABLE:     cfg_next.auto_enable     = cfg_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.app_count       <= APP_COUNT_RST;
            cfg_reg.ticks_per_app   <= TICKS_PER_APP_RST;
            cfg_reg.ticks_per_trans <= TICKS_PER_TRANS_RST;
            cfg_reg.auto_enable     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/dacs_step.sv
// ---------------------------------------------------------------------------
// Carousel sequencer event logic
// Applies one event to the sequencer state and forms the result item.
// ---------------------------------------------------------------------------
module dacs_step (
    input  dacs_pkg::dacs_cfg_t   cfg,
    input  dacs_pkg::dacs_state_t state,
    input  dacs_pkg::dacs_in_t    item,
    output dacs_pkg::dacs_state_t state_next,
    output dacs_pkg::dacs_out_t   result
);
    import dacs_pkg::*;

    logic [APP_CNT_W-1:0]  n_eff;
    logic [COUNT_BITS:0]   tick_sum;
    logic [COUNT_BITS-1:0] tick_sat;
    logic                  target_ok;
    logic [APP_BITS-1:0]   target_idx;
    logic                  switched;

    // Values above the rotation limit act as the limit.
    assign n_eff = (cfg.app_count > MAX_APPS_CNT) ? MAX_APPS_CNT : cfg.app_count;

    // Skipped ticks (only with auto enabled) and the tick itself in one saturating add.
    assign tick_sum = {1'b0, state.tick_counter}
                    + (cfg.auto_enable ? (COUNT_BITS+1)'(item.skipped_ticks) : '0)
                    + (COUNT_BITS+1)'(1);
    assign tick_sat = tick_sum[COUNT_BITS] ? COUNT_MAX : tick_sum[COUNT_BITS-1:0];

    assign target_ok  = {{(TARGET_W-APP_CNT_W){1'b0}}, n_eff} > item.target_app;
    assign target_idx = item.target_app[APP_BITS-1:0];

    always_comb
    begin
        state_next = state;
        switched   = 1'b0;
        case (item.action)
            ACT_TICK:
            begin
                state_next.tick_counter = tick_sat;
                if (n_eff != '0)
                begin
                    if (state.phase)
                    begin
                        if (tick_sat >= cfg.ticks_per_trans)
                        begin
                            state_next.current_index = dacs_neighbor(n_eff, state);
                            state_next.phase         = 1'b0;
                            state_next.tick_counter  = '0;
                            state_next.pending_valid = 1'b0;
                        end
                    end
                    else
                    begin
                        // The first fixed tick after a manual event restores forward travel.
                        if (state.manual_flag)
                        begin
                            state_next.dir_backward = 1'b0;
                            state_next.manual_flag  = 1'b0;
                        end
                        if (cfg.auto_enable && (tick_sat >= cfg.ticks_per_app))
                        begin
                            state_next.phase        = 1'b1;
                            state_next.tick_counter = '0;
                        end
                    end
                end
            end
            ACT_NEXT, ACT_PREV:
            begin
                if (!state.phase)
                begin
                    state_next.manual_flag  = 1'b1;
                    state_next.phase        = 1'b1;
                    state_next.tick_counter = '0;
                    state_next.dir_backward = (item.action == ACT_PREV);
                end
            end
            ACT_JUMP:
            begin
                if (target_ok)
                begin
                    state_next.tick_counter = '0;
                    if (target_idx != state.current_index)
                    begin
                        state_next.phase         = 1'b0;
                        state_next.current_index = target_idx;
                        switched                 = 1'b1;
                    end
                end
            end
            ACT_GOTO:
            begin
                if (target_ok)
                begin
                    state_next.tick_counter = '0;
                    if (target_idx != state.current_index)
                    begin
                        state_next.pending_valid = 1'b1;
                        state_next.pending_index = target_idx;
                        state_next.manual_flag   = 1'b1;
                        state_next.phase         = 1'b1;
                        state_next.dir_backward  = (target_idx < state.current_index);
                    end
                end
            end
            ACT_RESET:
            begin
                state_next.current_index = '0;
                state_next.tick_counter  = '0;
                state_next.phase         = 1'b0;
            end
            ACT_FORWARD:  state_next.dir_backward = 1'b0;
            ACT_BACKWARD: state_next.dir_backward = 1'b1;
            default:      state_next = state;
        endcase
    end

    always_comb
    begin
        result.current_app   = state_next.current_index;
        result.next_app      = dacs_neighbor(n_eff, state_next);
        result.transitioning = state_next.phase;
        result.tick_count    = state_next.tick_counter;
        result.backward      = state_next.dir_backward;
        result.switched      = switched;
    end

endmodule

### src/display_app_carousel_sequencer.sv
// Flow: an accepted event sits in the input register until the result register is
// free or drains, and the event logic then loads the result register.
// Throughput: one event per cycle unless out_ready holds the result register.
// Reset: asynchronous, active low; state clears to the fixed phase on app 0 and
// the configuration registers return to their defaults. No clearing pass.
// ---------------------------------------------------------------------------
// Display app carousel sequencer
// Chooses the displayed app of a rotation from tick, step, jump, go-to, reset and direction events.
// ---------------------------------------------------------------------------
module display_app_carousel_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dacs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dacs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  dacs_pkg::dacs_in_t              in_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output dacs_pkg::dacs_out_t             out_item
);
    import dacs_pkg::*;

    `include "display_app_carousel_sequencer_assert.svh"

    dacs_cfg_t   cfg;
    dacs_state_t state_reg;
    dacs_state_t state_next;
    dacs_in_t    in_item_reg;
    logic        in_valid_reg;
    dacs_out_t   result_next;
    dacs_out_t   out_item_reg;
    logic        out_valid_reg;
    logic        step_go;
    logic        jump_mid_trans;

    dacs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dacs_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // The registered event moves on whenever the result register is free or drains.
    assign step_go  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step_go)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_item;
        end
        if (step_go)
        begin
            out_item_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign jump_mid_trans = out_valid_reg && out_item_reg.switched
                          && out_item_reg.transitioning;

    `DACS_ASSERT_NEXT(a_held_event_kept, in_valid_reg && !step_go, in_valid_reg, "event lost")
    `DACS_ASSERT_NEXT(a_step_gives_result, step_go, out_valid_reg, "event gave no result")
    `DACS_ASSERT_NEXT(a_state_only_on_step, !step_go, $stable(state_reg), "stray state change")
    `DACS_ASSERT(a_jump_is_fixed, !jump_mid_trans, "switching jump left a transition running")

endmodule
